### rtl/core/aes256_cbc_encrypt_top_assert.svh
// Assertion macros shared by the block's modules
`ifndef AES256_CBC_ENCRYPT_TOP_ASSERT_SVH
`define AES256_CBC_ENCRYPT_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define ACBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ACBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/acbc_pkg.sv
`default_nettype none
package acbc_pkg;

    localparam int NUM_REGS = 6;
    localparam int KEY_WORDS = 60;

    typedef logic [127:0] t_block;

    typedef enum logic [2:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_IV_HI = 3'd4,
        REG_IV_LO = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYX,
        ST_ROUND,
        ST_DONE
    } t_state;

    // queue entry between front and back
    typedef struct packed {
        t_block data;
        logic   start;
    } t_job;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte i of the block sits at bits 127-8i; byte 4c+r is row r, column c
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

### rtl/core/acbc_front.sv
`default_nettype none
// Pads the incoming block and queues it for the round engine.
module acbc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [127:0]      i_text,
    input  wire logic [4:0]        i_count,
    input  wire logic              i_start,
    output logic                   o_job_valid,
    input  wire logic              i_job_ready,
    output acbc_pkg::t_job         o_job
);
    acbc_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    acbc_pkg::t_job w_job;
    logic [4:0]     w_n;
    logic [7:0]     w_pad;
    logic           w_push, w_pop;

    always_comb begin
        w_n   = (i_count > 5'd16) ? 5'd16 : i_count;
        w_pad = 8'd16 - {3'd0, w_n};
        w_job.start = i_start;
        for (int i = 0; i < 16; i++) begin
            w_job.data[127 - 8 * i -: 8] = (5'(i) < w_n) ? i_text[127 - 8 * i -: 8] : w_pad;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `include "aes256_cbc_encrypt_top_assert.svh"
    `ACBC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !w_push)
    `ACBC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, r_cnt == 2'd0, !w_pop)
    `ACBC_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, w_push && !w_pop, r_cnt != 2'd0)
endmodule
`default_nettype wire

### rtl/core/acbc_back.sv
`default_nettype none
// Key expansion (one word a cycle) and one AES round a cycle, CBC chain.
module acbc_back #(
    parameter int ROUNDS = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    output logic                o_job_ready,
    input  wire acbc_pkg::t_job i_job,
    input  wire logic [255:0]   i_key,
    input  wire logic [127:0]   i_iv,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [127:0]        o_data
);
    localparam int NW = 4 * (ROUNDS + 1);
    localparam int AW = $clog2(NW);
    localparam int RW = $clog2(ROUNDS + 1);

    // one entry per round key, schedule word 4r+c at bits 127-32c
    logic [127:0] r_rk [ROUNDS + 1];
    logic [31:0] r_win [8];
    acbc_pkg::t_state r_st, n_st;
    logic [AW-1:0] r_ki;
    logic [7:0]    r_rcon;
    logic [RW-1:0] r_rnd;
    logic [127:0]  r_s, r_chain, r_pend, r_out;
    logic          r_ov;
    logic [31:0]   w_t, w_nw;
    logic [127:0]  w_rk, w_ss, w_mix;
    logic          w_take, w_fin;

    assign o_job_ready = (r_st == acbc_pkg::ST_IDLE);
    assign w_take      = i_job_valid && o_job_ready;
    assign o_valid     = r_ov;
    assign o_data      = r_out;

    always_comb begin
        w_t = r_win[7];
        if (r_ki[2:0] == 3'd0) begin
            w_t = acbc_pkg::sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rcon, 24'd0};
        end else if (r_ki[2:0] == 3'd4) begin
            w_t = acbc_pkg::sub_word(r_win[7]);
        end
        w_nw = r_win[0] ^ w_t;
    end

    always_comb begin
        w_rk  = r_rk[r_rnd];
        w_ss  = acbc_pkg::sub_shift(r_s);
        w_mix = acbc_pkg::mix_columns(w_ss);
        w_fin = (r_rnd == RW'(ROUNDS));
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            acbc_pkg::ST_IDLE: begin
                if (w_take) n_st = i_job.start ? acbc_pkg::ST_KEYX : acbc_pkg::ST_ROUND;
            end
            acbc_pkg::ST_KEYX: begin
                if (r_ki == AW'(NW - 1)) n_st = acbc_pkg::ST_ROUND;
            end
            acbc_pkg::ST_ROUND: begin
                if (w_fin) n_st = acbc_pkg::ST_DONE;
            end
            acbc_pkg::ST_DONE: begin
                if (!r_ov || i_ready) n_st = acbc_pkg::ST_IDLE;
            end
            default: n_st = acbc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= acbc_pkg::ST_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_chain <= '0;
            r_out   <= '0;
        end else begin
            if (r_st == acbc_pkg::ST_DONE && (!r_ov || i_ready)) begin
                r_ov    <= 1'b1;
                r_out   <= r_pend;
                r_chain <= r_pend;
            end else begin
                if (r_ov && i_ready) r_ov <= 1'b0;
                if (w_take && i_job.start) r_chain <= i_iv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ki   <= AW'(8);
            r_rcon <= 8'h01;
            r_rnd  <= '0;
            r_s    <= i_job.data;
            for (int i = 0; i < 8; i++) r_win[i] <= i_key[255 - 32 * i -: 32];
            if (i_job.start) begin
                r_rk[0] <= i_key[255:128];
                r_rk[1] <= i_key[127:0];
            end
        end else if (r_st == acbc_pkg::ST_KEYX) begin
            r_rk[r_ki[AW-1:2]][127 - 32 * r_ki[1:0] -: 32] <= w_nw;
            for (int i = 0; i < 7; i++) r_win[i] <= r_win[i + 1];
            r_win[7] <= w_nw;
            r_ki <= r_ki + AW'(1);
            if (r_ki[2:0] == 3'd0) r_rcon <= acbc_pkg::xtime(r_rcon);
        end else if (r_st == acbc_pkg::ST_ROUND) begin
            // round 0 xors chain and key; last round skips mixing
            if (r_rnd == '0) r_s <= r_s ^ r_chain ^ w_rk;
            else if (w_fin) r_pend <= w_ss ^ w_rk;
            else r_s <= w_mix ^ w_rk;
            r_rnd <= r_rnd + RW'(1);
        end
    end

    `include "aes256_cbc_encrypt_top_assert.svh"
    `ACBC_ASSERT_IMP(a_busy_no_take, i_clk, i_rst_n,
        r_st != acbc_pkg::ST_IDLE, !o_job_ready)
    `ACBC_ASSERT_NXT(a_fin_done, i_clk, i_rst_n,
        r_st == acbc_pkg::ST_ROUND && w_fin, r_st == acbc_pkg::ST_DONE)
    `ACBC_ASSERT_IMP(a_hold_out, i_clk, i_rst_n,
        r_st == acbc_pkg::ST_DONE && r_ov && !i_ready, n_st == acbc_pkg::ST_DONE)
endmodule
`default_nettype wire

### rtl/core/aes256_cbc_encrypt_top.sv
// Channel  | Dir | Payload
// s_axis   | in  | tdata: plaintext_high, plaintext_low, valid_bytes, message_start
// m_axis   | out | tdata: ciphertext_high, ciphertext_low
// apb      | in  | key_word0..3, iv_high, iv_low at 8*i, 64-bit data
// In the round engine an item passes through the take, 15 round
// steps and a hand-off into the output register.
// A message start adds key expansion of 52 schedule words, one schedule word a cycle.
// Reset is synchronous, active low; it clears control, chain, output and the key and IV registers.
// A two-entry queue lets the input accept while the engine works; a held
// result stalls the engine until taken.
`default_nettype none
module aes256_cbc_encrypt_top #(
    parameter int ROUNDS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] plaintext_high, [127:64] plaintext_low, [132:128] valid_bytes,
    // [133] message_start, [135:134] zero
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] ciphertext_high, [127:64] ciphertext_low
    output logic [127:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    logic [63:0]    r_regs [acbc_pkg::NUM_REGS];
    logic [2:0]     w_idx;
    logic           w_jv, w_jr, w_ov;
    acbc_pkg::t_job w_job;
    logic [127:0]   w_ct;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < acbc_pkg::NUM_REGS; i++) r_regs[i] <= '0;
        end else if (psel && penable && pwrite && w_idx < 3'(acbc_pkg::NUM_REGS)) begin
            r_regs[w_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx < 3'(acbc_pkg::NUM_REGS)) prdata = r_regs[w_idx];
    end

    acbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_text     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_count    (s_axis_tdata[132:128]),
        .i_start    (s_axis_tdata[133]),
        .o_job_valid(w_jv),
        .i_job_ready(w_jr),
        .o_job      (w_job)
    );

    acbc_back #(.ROUNDS(ROUNDS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_jv),
        .o_job_ready(w_jr),
        .i_job      (w_job),
        .i_key      ({r_regs[acbc_pkg::REG_KEY0], r_regs[acbc_pkg::REG_KEY1],
                      r_regs[acbc_pkg::REG_KEY2], r_regs[acbc_pkg::REG_KEY3]}),
        .i_iv       ({r_regs[acbc_pkg::REG_IV_HI], r_regs[acbc_pkg::REG_IV_LO]}),
        .o_valid    (w_ov),
        .i_ready    (m_axis_tready),
        .o_data     (w_ct)
    );

    assign m_axis_tvalid = w_ov;
    assign m_axis_tdata  = {w_ct[63:0], w_ct[127:64]};
endmodule
`default_nettype wire

### bench/aes_cbc_checker.sv
`timescale 1ns / 100ps
module aes_cbc_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [127:0] m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    input  wire logic         pready,
    output int                o_errors,
    output int                o_pending
);
    logic [63:0] key_iv_regs [acbc_pkg::NUM_REGS];
    logic [31:0] sched [acbc_pkg::KEY_WORDS];
    logic [63:0] chain_hi, chain_lo;
    logic [7:0]  sbox_tbl [256];
    logic [127:0] cipher_q [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // S-box built from the GF(2^8) inverse and the affine map
    initial begin
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
            b = inv;
            sbox_tbl[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                        ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
    end

    function automatic logic [31:0] sub4(input logic [31:0] w);
        return {sbox_tbl[w[31:24]], sbox_tbl[w[23:16]], sbox_tbl[w[15:8]], sbox_tbl[w[7:0]]};
    endfunction

    task automatic load_schedule();
        logic [7:0]  rc;
        logic [31:0] t;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            sched[i] = i[0] ? key_iv_regs[i >> 1][31:0] : key_iv_regs[i >> 1][63:32];
        for (int i = 8; i < acbc_pkg::KEY_WORDS; i++) begin
            t = sched[i - 1];
            if ((i & 7) == 0) begin
                t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end else if ((i & 7) == 4) begin
                t = sub4(t);
            end
            sched[i] = sched[i - 8] ^ t;
        end
    endtask

    // pads, chains and encrypts one block; returns {high, low}
    task automatic encrypt_next(input logic [63:0] ph, input logic [63:0] pl,
                                input logic [4:0] cnt, input logic start,
                                output logic [127:0] ct);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] pad, a0, a1, a2, a3, al;
        logic [127:0] pt, chn;
        int n;
        n = (cnt > 16) ? 16 : cnt;
        pad = 8'(16 - n);
        if (start) begin
            chain_hi = key_iv_regs[acbc_pkg::REG_IV_HI];
            chain_lo = key_iv_regs[acbc_pkg::REG_IV_LO];
            load_schedule();
        end
        pt = {ph, pl};
        chn = {chain_hi, chain_lo};
        for (int i = 0; i < 16; i++)
            s[i] = ((i < n) ? pt[127 - 8 * i -: 8] : pad) ^ chn[127 - 8 * i -: 8];
        for (int rnd = 0; rnd <= 14; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4 * c + r] = sbox_tbl[s[4 * ((c + r) & 3) + r]];
                s = t;
            end
            if (rnd > 0 && rnd < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ al ^ dbl(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ al ^ dbl(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ al ^ dbl(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
        end
        for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
        {chain_hi, chain_lo} = ct;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        logic [127:0] ct, want;
        if (!i_rst_n) begin
            foreach (key_iv_regs[i]) key_iv_regs[i] = '0;
            chain_hi = '0;
            chain_lo = '0;
            cipher_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[5:3] < acbc_pkg::NUM_REGS)
                key_iv_regs[paddr[5:3]] = pwdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    report("unexpected ciphertext item", m_axis_tdata[63:0], 64'h0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_axis_tdata[63:0] != want[127:64])
                        report("ciphertext_high", m_axis_tdata[63:0], want[127:64]);
                    if (m_axis_tdata[127:64] != want[63:0])
                        report("ciphertext_low", m_axis_tdata[127:64], want[63:0]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                encrypt_next(s_axis_tdata[63:0], s_axis_tdata[127:64],
                             s_axis_tdata[132:128], s_axis_tdata[133], ct);
                cipher_q.push_back(ct);
            end
        end
    end
endmodule

### bench/tb.sv
`timescale 1ns / 100ps
module tb;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [63:0] plaintext_high, [127:64] plaintext_low, [132:128] valid_bytes,
    // [133] message_start, [135:134] zero
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [63:0] ciphertext_high, [127:64] ciphertext_low
    logic [127:0] m_axis_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    int           errors, pending;
    bit           quiet = 0;
    bit           hold_req = 0;
    int           item_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    aes256_cbc_encrypt_top i_dut (.*);

    aes_cbc_checker i_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        #20ms;
        $display("aes256_cbc_encrypt_top test failed");
        $finish;
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial begin
        int burst, hold;
        burst = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else if (quiet) begin
                m_axis_tready = 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_axis_tready = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 3);
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 3'b000}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic load_key_iv(input logic [63:0] k0, k1, k2, k3, ivh, ivl);
        reg_write(acbc_pkg::REG_KEY0, k0);
        reg_write(acbc_pkg::REG_KEY1, k1);
        reg_write(acbc_pkg::REG_KEY2, k2);
        reg_write(acbc_pkg::REG_KEY3, k3);
        reg_write(acbc_pkg::REG_IV_HI, ivh);
        reg_write(acbc_pkg::REG_IV_LO, ivl);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_block(input logic [63:0] ph, pl, input logic [4:0] cnt,
                              input logic start);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, start, cnt, pl, ph};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        item_count++;
    endtask

    task automatic random_message(input int len);
        logic [4:0] cnt;
        for (int k = 0; k < len; k++) begin
            cnt = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
            send_block(rand64(), rand64(), cnt, k == 0);
        end
    endtask

    task automatic close_phase();
        s_axis_tvalid = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // all-zero key and IV; padding and count extremes
        load_key_iv('0, '0, '0, '0, '0, '0);
        send_block('0, '0, 5'd16, 1'b1);
        send_block('1, '1, 5'd0, 1'b0);
        send_block('1, '1, 5'd1, 1'b0);
        send_block(rand64(), rand64(), 5'd8, 1'b0);
        send_block(rand64(), rand64(), 5'd15, 1'b0);
        send_block('1, '0, 5'd17, 1'b0);
        send_block('0, '1, 5'd31, 1'b1);
        send_block(rand64(), rand64(), 5'd7, 1'b0);
        close_phase();

        // all-ones key and IV
        load_key_iv('1, '1, '1, '1, '1, '1);
        // writes past the last register are dropped
        reg_write(3'd6, '1);
        reg_write(3'd7, rand64());
        send_block('1, '1, 5'd16, 1'b1);
        send_block('0, '0, 5'd0, 1'b0);
        send_block(rand64(), rand64(), 5'd9, 1'b0);
        close_phase();

        // new key mid-message takes effect only at the next start
        load_key_iv(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        send_block(rand64(), rand64(), 5'd16, 1'b0);
        send_block(rand64(), rand64(), 5'd4, 1'b1);
        send_block(rand64(), rand64(), 5'd16, 1'b0);

        // long output hold-off while input keeps coming
        hold_req = 1;
        random_message(12);
        close_phase();

        for (int ph = 0; ph < 6; ph++) begin
            load_key_iv(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
            while (item_count < 280 * (ph + 1)) begin
                if (ph == 5 && item_count > 1500) quiet = 1;
                random_message($urandom_range(1, 8));
            end
            close_phase();
        end

        if (errors == 0) begin
            $display("aes256_cbc_encrypt_top test passed");
        end else begin
            $display("aes256_cbc_encrypt_top test failed");
        end
        $finish;
    end
endmodule
